FILE: rtl/core/psf_pkg.sv
// psf_pkg: shared helpers for the polyline segment frame block
// no dependencies; imported by every unit and the top level
package psf_pkg;

   // bits a step counter needs to count up to and including steps
   function automatic int psf_cnt_bits(input int steps);
      return $clog2(steps + 1);
   endfunction

endpackage

FILE: rtl/core/psf_if.sv
// psf_if: point, segment and control register channels of the segment frame block
// valid/ready handshake, a beat moves when both are high; no package needed
interface psf_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          last_point;

   modport source(output valid, point_x, point_y, last_point, input ready);
   modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

interface psf_rsp_if #(parameter int COORD_WIDTH = 16, parameter int UNIT_FRAC_BITS = 14);
   logic                             valid;
   logic                             ready;
   logic signed [COORD_WIDTH:0]      delta_x;
   logic signed [COORD_WIDTH:0]      delta_y;
   logic [COORD_WIDTH:0]             seg_length;
   logic signed [UNIT_FRAC_BITS+1:0] tangent_x;
   logic signed [UNIT_FRAC_BITS+1:0] tangent_y;
   logic signed [UNIT_FRAC_BITS+1:0] normal_x;
   logic signed [UNIT_FRAC_BITS+1:0] normal_y;
   logic                             zero_length;
   logic                             final_segment;

   modport source(output valid, delta_x, delta_y, seg_length, tangent_x, tangent_y,
                  normal_x, normal_y, zero_length, final_segment, input ready);
   modport sink(input valid, delta_x, delta_y, seg_length, tangent_x, tangent_y,
                normal_x, normal_y, zero_length, final_segment, output ready);
endinterface

interface psf_csr_if;
   logic valid;
   logic ready;
   logic closed_loop;

   modport source(output valid, closed_loop, input ready);
   modport sink(input valid, closed_loop, output ready);
endinterface

FILE: rtl/core/psf_sumsq.sv
// psf_sumsq: bit-serial sum of two squares, one multiplier bit of each per cycle
// uses psf_pkg for the counter width
module psf_sumsq #(
   parameter int MAG_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] mag_x,
   input  logic [MAG_W-1:0] mag_y,
   output logic [2*MAG_W:0] sum,
   output logic             done
);
   import psf_pkg::*;

   localparam int SUM_W = 2 * MAG_W + 1;
   localparam int CNT_W = psf_cnt_bits(MAG_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] mcx_ff, mcx_in;
   logic [SUM_W-1:0] mcy_ff, mcy_in;
   logic [MAG_W-1:0] mpx_ff, mpx_in;
   logic [MAG_W-1:0] mpy_ff, mpy_in;
   logic [SUM_W-1:0] acc_ff, acc_in;

   // shift-add step: multiplier bits leave at the bottom, multiplicands move up
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mcx_in  = mcx_ff;
      mcy_in  = mcy_ff;
      mpx_in  = mpx_ff;
      mpy_in  = mpy_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mcx_in  = SUM_W'(mag_x);
         mcy_in  = SUM_W'(mag_y);
         mpx_in  = mag_x;
         mpy_in  = mag_y;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + ({SUM_W{mpx_ff[0]}} & mcx_ff) + ({SUM_W{mpy_ff[0]}} & mcy_ff);
         mcx_in = mcx_ff << 1;
         mcy_in = mcy_ff << 1;
         mpx_in = mpx_ff >> 1;
         mpy_in = mpy_ff >> 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      mcx_ff <= mcx_in;
      mcy_ff <= mcy_in;
      mpx_ff <= mpx_in;
      mpy_ff <= mpy_in;
      acc_ff <= acc_in;
   end

   assign sum  = acc_ff;
   assign done = done_ff;

endmodule

FILE: rtl/core/psf_isqrt.sv
// psf_isqrt: restoring integer square root, one radicand digit pair per cycle
// uses psf_pkg for the counter width
module psf_isqrt #(
   parameter int ROOT_W = 17
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2*ROOT_W-1:0] radicand,
   output logic [ROOT_W-1:0]   root,
   output logic                done
);
   import psf_pkg::*;

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 1;
   localparam int TRY_W = ROOT_W + 3;
   localparam int CNT_W = psf_cnt_bits(ROOT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [TRY_W-1:0]  rem_sh;
   logic [TRY_W-1:0]  trial;
   logic [TRY_W-1:0]  diff;
   logic              fits;

   // bring down the next digit pair and try the trial subtrahend 4*root+1
   assign rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign diff   = rem_sh - trial;
   assign fits   = (rem_sh >= trial);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

FILE: rtl/core/psf_div.sv
// psf_div: restoring divider for (numer << FRAC_W) / denom, one quotient bit per cycle
// numer must not exceed denom; uses psf_pkg for the counter width
module psf_div #(
   parameter int NUM_W  = 16,
   parameter int DEN_W  = 17,
   parameter int FRAC_W = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  numer,
   input  logic [DEN_W-1:0]  denom,
   output logic [FRAC_W:0]   quot,
   output logic              done
);
   import psf_pkg::*;

   localparam int STEPS = FRAC_W + 1;
   localparam int CNT_W = psf_cnt_bits(STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [FRAC_W:0]  quot_ff, quot_in;
   logic [DEN_W:0]   rem_t;
   logic [DEN_W:0]   diff;
   logic             fits;

   // first step compares the numerator itself, later steps shift in zeros
   assign rem_t = (cnt_ff == '0) ? (DEN_W + 1)'(num_ff) : {rem_ff, 1'b0};
   assign diff  = rem_t - {1'b0, den_ff};
   assign fits  = (rem_t >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : rem_t[DEN_W-1:0];
         quot_in = {quot_ff[FRAC_W-1:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

FILE: rtl/core/polyline_segment_frames_top.sv
// polyline_segment_frames_top: segment vector, length and unit frame per polyline segment
// per segment the bit-serial squarer, the square root and then the two dividers, which run
// side by side, work one after another; one point beat in flight: the next beat is taken
// only once the segment, and any closing pass, has been emitted, and later on rsp stall
// reset (synchronous, active high) clears the stored joints, the open/closed mode and all valids
// uses psf_pkg, psf_if, psf_sumsq, psf_isqrt, psf_div
module polyline_segment_frames_top #(
   parameter int COORD_WIDTH    = 16,
   parameter int UNIT_FRAC_BITS = 14
) (
   input  logic   clock,
   input  logic   reset,
   psf_req_if.sink   req,
   psf_rsp_if.source rsp,
   psf_csr_if.sink   csr
);
   import psf_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int DW    = COORD_WIDTH + 1;
   localparam int UW    = UNIT_FRAC_BITS + 2;
   localparam int SUM_W = 2 * COORD_WIDTH + 1;
   localparam int RAD_W = 2 * DW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQ,
      S_ROOT,
      S_DIV,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic              closed_ff, closed_in;
   logic              have_prev_ff, have_prev_in;
   logic              pend_close_ff, pend_close_in;
   logic              sq_start_ff, sq_start_in;
   logic              rt_start_ff, rt_start_in;
   logic              dv_start_ff, dv_start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]     first_x_ff, first_x_in;
   logic [CW-1:0]     first_y_ff, first_y_in;
   logic [CW-1:0]     prev_x_ff, prev_x_in;
   logic [CW-1:0]     prev_y_ff, prev_y_in;
   logic [DW-1:0]     dx_ff, dx_in;
   logic [DW-1:0]     dy_ff, dy_in;
   logic              fin_ff, fin_in;
   logic [DW-1:0]     len_ff, len_in;
   logic [DW-1:0]     o_dx_ff, o_dx_in;
   logic [DW-1:0]     o_dy_ff, o_dy_in;
   logic [DW-1:0]     o_len_ff, o_len_in;
   logic [UW-1:0]     o_tx_ff, o_tx_in;
   logic [UW-1:0]     o_ty_ff, o_ty_in;
   logic              o_zero_ff, o_zero_in;
   logic              o_fin_ff, o_fin_in;

   logic              req_beat;
   logic [DW-1:0]     in_dx;
   logic [DW-1:0]     in_dy;
   logic [DW-1:0]     close_dx;
   logic [DW-1:0]     close_dy;
   logic [DW-1:0]     abs_x;
   logic [DW-1:0]     abs_y;
   logic [CW-1:0]     mag_x;
   logic [CW-1:0]     mag_y;
   logic [SUM_W-1:0]  sq_sum;
   logic              sq_done;
   logic [DW-1:0]     rt_root;
   logic              rt_done;
   logic [UNIT_FRAC_BITS:0] qx;
   logic [UNIT_FRAC_BITS:0] qy;
   logic              dvx_done;
   logic              dvy_done;
   logic [UW-1:0]     ux;
   logic [UW-1:0]     uy;
   logic              len_zero;
   logic              out_free;

   // handshakes
   assign req.ready = (state_ff == S_IDLE);
   assign req_beat  = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // segment vectors, sign-extended differences
   assign in_dx    = {req.point_x[CW-1], req.point_x} - {prev_x_ff[CW-1], prev_x_ff};
   assign in_dy    = {req.point_y[CW-1], req.point_y} - {prev_y_ff[CW-1], prev_y_ff};
   assign close_dx = {first_x_ff[CW-1], first_x_ff} - {prev_x_ff[CW-1], prev_x_ff};
   assign close_dy = {first_y_ff[CW-1], first_y_ff} - {prev_y_ff[CW-1], prev_y_ff};

   // magnitudes fit the coordinate width since |delta| < 2^CW
   assign abs_x = dx_ff[DW-1] ? (DW'(0) - dx_ff) : dx_ff;
   assign abs_y = dy_ff[DW-1] ? (DW'(0) - dy_ff) : dy_ff;
   assign mag_x = abs_x[CW-1:0];
   assign mag_y = abs_y[CW-1:0];

   // signed unit components, zero for a zero-length segment
   assign len_zero = (len_ff == '0);
   assign ux = len_zero ? '0 : (dx_ff[DW-1] ? (UW'(0) - UW'(qx)) : UW'(qx));
   assign uy = len_zero ? '0 : (dy_ff[DW-1] ? (UW'(0) - UW'(qy)) : UW'(qy));

   psf_sumsq #(.MAG_W(CW)) u_sumsq (
      .clock (clock),
      .reset (reset),
      .start (sq_start_ff),
      .mag_x (mag_x),
      .mag_y (mag_y),
      .sum   (sq_sum),
      .done  (sq_done)
   );

   psf_isqrt #(.ROOT_W(DW)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start_ff),
      .radicand (RAD_W'(sq_sum)),
      .root     (rt_root),
      .done     (rt_done)
   );

   psf_div #(.NUM_W(CW), .DEN_W(DW), .FRAC_W(UNIT_FRAC_BITS)) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (dv_start_ff),
      .numer (mag_x),
      .denom (len_ff),
      .quot  (qx),
      .done  (dvx_done)
   );

   psf_div #(.NUM_W(CW), .DEN_W(DW), .FRAC_W(UNIT_FRAC_BITS)) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (dv_start_ff),
      .numer (mag_y),
      .denom (len_ff),
      .quot  (qy),
      .done  (dvy_done)
   );

   // sequencer: joint bookkeeping, unit hand-over and result register load
   always_comb begin
      state_in      = state_ff;
      closed_in     = closed_ff;
      have_prev_in  = have_prev_ff;
      pend_close_in = pend_close_ff;
      sq_start_in   = 1'b0;
      rt_start_in   = 1'b0;
      dv_start_in   = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      fin_in        = fin_ff;
      len_in        = len_ff;
      o_dx_in       = o_dx_ff;
      o_dy_in       = o_dy_ff;
      o_len_in      = o_len_ff;
      o_tx_in       = o_tx_ff;
      o_ty_in       = o_ty_ff;
      o_zero_in     = o_zero_ff;
      o_fin_in      = o_fin_ff;

      // mode register write
      if (csr.valid && csr.ready) begin
         closed_in = csr.closed_loop;
      end

      // result beat taken downstream
      if (rsp.valid && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               prev_x_in = req.point_x;
               prev_y_in = req.point_y;
               if (!have_prev_ff) begin
                  first_x_in = req.point_x;
                  first_y_in = req.point_y;
                  have_prev_in = !req.last_point;
                  // lone final joint closes on itself in closed mode
                  if (req.last_point && closed_ff) begin
                     dx_in         = '0;
                     dy_in         = '0;
                     fin_in        = 1'b1;
                     pend_close_in = 1'b0;
                     sq_start_in   = 1'b1;
                     state_in      = S_SQ;
                  end
               end else begin
                  dx_in         = in_dx;
                  dy_in         = in_dy;
                  fin_in        = req.last_point && !closed_ff;
                  pend_close_in = req.last_point && closed_ff;
                  have_prev_in  = !req.last_point;
                  sq_start_in   = 1'b1;
                  state_in      = S_SQ;
               end
            end
         end
         S_SQ: begin
            if (sq_done) begin
               rt_start_in = 1'b1;
               state_in    = S_ROOT;
            end
         end
         S_ROOT: begin
            if (rt_done) begin
               len_in      = rt_root;
               dv_start_in = 1'b1;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            if (dvx_done && dvy_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_dx_in      = dx_ff;
               o_dy_in      = dy_ff;
               o_len_in     = len_ff;
               o_tx_in      = ux;
               o_ty_in      = uy;
               o_zero_in    = len_zero;
               o_fin_in     = fin_ff;
               // closing segment from the final joint back to the first
               if (pend_close_ff) begin
                  dx_in         = close_dx;
                  dy_in         = close_dy;
                  fin_in        = 1'b1;
                  pend_close_in = 1'b0;
                  sq_start_in   = 1'b1;
                  state_in      = S_SQ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         closed_ff     <= 1'b0;
         have_prev_ff  <= 1'b0;
         pend_close_ff <= 1'b0;
         sq_start_ff   <= 1'b0;
         rt_start_ff   <= 1'b0;
         dv_start_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         closed_ff     <= closed_in;
         have_prev_ff  <= have_prev_in;
         pend_close_ff <= pend_close_in;
         sq_start_ff   <= sq_start_in;
         rt_start_ff   <= rt_start_in;
         dv_start_ff   <= dv_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         first_x_ff    <= first_x_in;
         first_y_ff    <= first_y_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
      end
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      fin_ff    <= fin_in;
      len_ff    <= len_in;
      o_dx_ff   <= o_dx_in;
      o_dy_ff   <= o_dy_in;
      o_len_ff  <= o_len_in;
      o_tx_ff   <= o_tx_in;
      o_ty_ff   <= o_ty_in;
      o_zero_ff <= o_zero_in;
      o_fin_ff  <= o_fin_in;
   end

   // result channel
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.delta_x       = o_dx_ff;
   assign rsp.delta_y       = o_dy_ff;
   assign rsp.seg_length    = o_len_ff;
   assign rsp.tangent_x     = o_tx_ff;
   assign rsp.tangent_y     = o_ty_ff;
   assign rsp.normal_x      = UW'(0) - o_ty_ff;
   assign rsp.normal_y      = o_tx_ff;
   assign rsp.zero_length   = o_zero_ff;
   assign rsp.final_segment = o_fin_ff;

endmodule

FILE: tb/sv/polyline_segment_frames_top_tb.sv
// polyline_segment_frames_top_tb: self-checking bench for the polyline segment frame block
// drives joint beats, predicts every segment frame and checks it against the result channel
// depends on psf_if (point, segment and control channels) and polyline_segment_frames_top
module polyline_segment_frames_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W     = 16;
   localparam int UNIT_FRAC   = 14;
   localparam int SETTLE      = 200;        // room for a segment and its closing pass, with margin
   localparam int CYCLE_LIMIT = 1_000_000;

   // one expected segment frame
   typedef struct {
      logic signed [COORD_W:0]     delta_x;
      logic signed [COORD_W:0]     delta_y;
      logic        [COORD_W:0]     seg_length;
      logic signed [UNIT_FRAC+1:0] tangent_x;
      logic signed [UNIT_FRAC+1:0] tangent_y;
      logic signed [UNIT_FRAC+1:0] normal_x;
      logic signed [UNIT_FRAC+1:0] normal_y;
      logic                        zero_length;
      logic                        final_segment;
   } seg_frame_type;

   logic clock;
   logic reset;

   psf_req_if #(.COORD_WIDTH(COORD_W)) req_ch ();
   psf_rsp_if #(.COORD_WIDTH(COORD_W), .UNIT_FRAC_BITS(UNIT_FRAC)) rsp_ch ();
   psf_csr_if csr_ch ();

   polyline_segment_frames_top #(
      .COORD_WIDTH    (COORD_W),
      .UNIT_FRAC_BITS (UNIT_FRAC)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // predictor state: joints of the open polyline and the mode
   logic signed [COORD_W-1:0] joint_first_x, joint_first_y;
   logic signed [COORD_W-1:0] joint_prev_x, joint_prev_y;
   bit                        joint_open;
   bit                        loop_closed;

   seg_frame_type pending_frames[$];
   int            mismatches;
   int            points_sent;
   int            cycles;
   int            tx_idle_pct;
   int            rx_idle_pct;
   int            hold_cycles;

   // generator memory for near-previous joints
   logic signed [COORD_W-1:0] gen_x, gen_y;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // result ready: random idling, or a long hold-off when asked
   initial begin
      rsp_ch.ready <= 1'b0;
      hold_cycles  <= 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // floor of the square root, one result bit at a time
   function automatic longint unsigned floor_root(input longint unsigned sq);
      longint unsigned root, trial;
      root = 0;
      for (int i = COORD_W + 1; i >= 0; i--) begin
         trial = root | (longint'(1) << i);
         if (trial * trial <= sq) root = trial;
      end
      return root;
   endfunction

   // frame of the segment from a to b
   function automatic seg_frame_type segment_frame(input longint ax, input longint ay,
                                                   input longint bx, input longint by,
                                                   input bit fin);
      seg_frame_type   f;
      longint          dx, dy, tx, ty, nx;
      longint unsigned mx, my, len;
      dx  = bx - ax;
      dy  = by - ay;
      mx  = (dx < 0) ? -dx : dx;
      my  = (dy < 0) ? -dy : dy;
      len = floor_root(mx * mx + my * my);
      tx  = 0;
      ty  = 0;
      if (len != 0) begin
         tx = longint'((mx << UNIT_FRAC) / len);
         ty = longint'((my << UNIT_FRAC) / len);
         if (dx < 0) tx = -tx;
         if (dy < 0) ty = -ty;
      end
      nx              = -ty;
      f.delta_x       = dx[COORD_W:0];
      f.delta_y       = dy[COORD_W:0];
      f.seg_length    = len[COORD_W:0];
      f.tangent_x     = tx[UNIT_FRAC+1:0];
      f.tangent_y     = ty[UNIT_FRAC+1:0];
      f.normal_x      = nx[UNIT_FRAC+1:0];
      f.normal_y      = tx[UNIT_FRAC+1:0];
      f.zero_length   = (len == 0);
      f.final_segment = fin;
      return f;
   endfunction

   // advance the predictor by one accepted joint
   task automatic predict_joint(input logic signed [COORD_W-1:0] px,
                                input logic signed [COORD_W-1:0] py, input logic last);
      if (!joint_open) begin
         joint_first_x = px;
         joint_first_y = py;
         // lone final joint closes onto itself in closed mode only
         if (last && loop_closed)
            pending_frames = {pending_frames, segment_frame(px, py, px, py, 1'b1)};
         joint_open = !last;
      end else begin
         pending_frames = {pending_frames, segment_frame(joint_prev_x, joint_prev_y, px, py,
                                                         last && !loop_closed)};
         if (last && loop_closed)
            pending_frames = {pending_frames, segment_frame(px, py, joint_first_x,
                                                            joint_first_y, 1'b1)};
         if (last) joint_open = 1'b0;
      end
      joint_prev_x = px;
      joint_prev_y = py;
   endtask

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // result checker
   initial begin
      seg_frame_type f;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_frames.size() == 0) begin
               $error("segment beat with no frame expected");
               mismatches++;
            end else begin
               f = pending_frames.pop_front();
               compare_field("delta_x", f.delta_x, rsp_ch.delta_x);
               compare_field("delta_y", f.delta_y, rsp_ch.delta_y);
               compare_field("seg_length", f.seg_length, rsp_ch.seg_length);
               compare_field("tangent_x", f.tangent_x, rsp_ch.tangent_x);
               compare_field("tangent_y", f.tangent_y, rsp_ch.tangent_y);
               compare_field("normal_x", f.normal_x, rsp_ch.normal_x);
               compare_field("normal_y", f.normal_y, rsp_ch.normal_y);
               compare_field("zero_length", f.zero_length, rsp_ch.zero_length);
               compare_field("final_segment", f.final_segment, rsp_ch.final_segment);
            end
         end
      end
   end

   // offer one joint beat and wait for it to be taken
   task automatic send_joint(input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.point_x    <= px;
      req_ch.point_y    <= py;
      req_ch.last_point <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_joint(px, py, last);
      points_sent++;
      gen_x = px;
      gen_y = py;
   endtask

   // drop valid and wait until every frame has come and the block has settled
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(input bit closed);
      wait_drained();
      csr_ch.valid       <= 1'b1;
      csr_ch.closed_loop <= closed;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      loop_closed  = closed;
   endtask

   // one coordinate: full range, near the last joint, repeated or at the extremes
   function automatic logic signed [COORD_W-1:0] pick_coord(input logic signed [COORD_W-1:0] near);
      int sel, off;
      sel = $urandom_range(99);
      if (sel < 35) return COORD_W'($urandom);
      if (sel < 70) begin
         off = $urandom_range(512) - 256;
         return COORD_W'(int'(near) + off);
      end
      if (sel < 80) return near;
      if (sel < 90) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      off = $urandom_range(6) - 3;
      return COORD_W'(int'(near) + off);
   endfunction

   task automatic send_polyline(input int joints);
      logic signed [COORD_W-1:0] px, py;
      for (int i = 0; i < joints; i++) begin
         // repeated joint gives a zero-length segment
         if ($urandom_range(99) < 8) begin
            px = gen_x;
            py = gen_y;
         end else begin
            px = pick_coord(gen_x);
            py = pick_coord(gen_y);
         end
         send_joint(px, py, i == joints - 1);
      end
   endtask

   task automatic test_open_directed();
      write_mode(1'b0);
      // lone final joint: nothing comes out
      send_joint(16'sd0, 16'sd0, 1'b1);
      // corner to corner, widest segment, then a repeated joint
      send_joint(16'sh8000, 16'sh8000, 1'b0);
      send_joint(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_joint(16'sh7FFF, 16'sh8000, 1'b0);
      send_joint(16'sh7FFF, 16'sh8000, 1'b0);
      send_joint(16'sh8000, 16'sh7FFF, 1'b0);
      send_joint(16'sd0, 16'sd0, 1'b1);
      // two-joint polyline, short step of two along x
      send_joint(16'sd1, 16'sd0, 1'b0);
      send_joint(-16'sd1, 16'sd0, 1'b1);
   endtask

   task automatic test_closed_directed();
      write_mode(1'b1);
      // lone final joint closes onto itself
      send_joint(16'sh1234, -16'sd5, 1'b1);
      // triangle with a closing segment
      send_joint(16'sd256, 16'sd0, 1'b0);
      send_joint(16'sd0, 16'sd256, 1'b0);
      send_joint(-16'sd256, -16'sd256, 1'b1);
      // last joint on top of the first: closing segment has zero length
      send_joint(16'sd100, 16'sd100, 1'b0);
      send_joint(16'sd200, -16'sd300, 1'b0);
      send_joint(16'sd100, 16'sd100, 1'b1);
      // closing across the full range
      send_joint(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_joint(16'sh8000, 16'sh8000, 1'b1);
   endtask

   task automatic test_random_polylines(input int joints_wanted);
      int target;
      target = points_sent + joints_wanted;
      while (points_sent < target) begin
         if ($urandom_range(99) < 10) send_polyline(1);
         else send_polyline($urandom_range(8, 2));
         // mode changes only between polylines, with the block idle
         if ($urandom_range(99) < 7) write_mode(!loop_closed);
      end
   endtask

   // receiver holds off for a long stretch while joints keep coming
   task automatic test_result_hold_off();
      req_ch.valid <= 1'b0;
      hold_cycles  <= 600;
      @(posedge clock);
      send_polyline(12);
      write_mode(1'b1);
      hold_cycles <= 600;
      @(posedge clock);
      send_polyline(12);
   endtask

   // sender stops until every frame has come, then carries on mid-stream
   task automatic test_drain_pause();
      send_polyline(5);
      req_ch.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      send_polyline(6);
      req_ch.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      send_polyline(3);
   endtask

   // main sequence
   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.point_x     <= '0;
      req_ch.point_y     <= '0;
      req_ch.last_point  <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.closed_loop <= 1'b0;
      joint_first_x = '0;
      joint_first_y = '0;
      joint_prev_x  = '0;
      joint_prev_y  = '0;
      joint_open    = 1'b0;
      loop_closed   = 1'b0;
      gen_x         = '0;
      gen_y         = '0;
      mismatches    = 0;
      points_sent   = 0;
      tx_idle_pct   = 32;
      rx_idle_pct   = 87;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_open_directed();
      test_closed_directed();
      test_random_polylines(300);
      test_result_hold_off();

      tx_idle_pct = 87;
      rx_idle_pct = 32;
      test_random_polylines(300);
      test_drain_pause();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_mode(1'b0);
      test_random_polylines(300);

      wait_drained();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/psf_pkg.sv
rtl/core/psf_if.sv
rtl/core/psf_sumsq.sv
rtl/core/psf_isqrt.sv
rtl/core/psf_div.sv
rtl/core/polyline_segment_frames_top.sv
tb/sv/polyline_segment_frames_top_tb.sv
